@@ rtl/core/cpa_pkg.sv @@
// cpa_pkg: types and constants for the camera pixel to ARGB32 converter
// no dependencies; imported by camera_pixel_to_argb32_top and the testbench
`default_nettype none

package cpa_pkg;

  // source pixel layouts held in the format register
  typedef enum logic [1:0] {
    FMT_RGB24  = 2'd0,
    FMT_YUYV   = 2'd1,
    FMT_RGB565 = 2'd2,
    FMT_RGB444 = 2'd3
  } src_fmt_t;

  // one source byte group
  typedef struct packed {
    logic [7:0] byte_zero;
    logic [7:0] byte_one;
    logic [7:0] byte_two;
    logic [7:0] byte_three;
    logic       frame_end;
  } in_word_t;

  // one converted pixel
  typedef struct packed {
    logic [31:0] pixel_argb;
    logic        last_of_item;
    logic        frame_end_out;
  } out_word_t;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  // bt.601 integer conversion terms
  localparam logic [8:0]         LUMA_OFFSET   = 9'd16;
  localparam logic [8:0]         CHROMA_OFFSET = 9'd128;
  localparam logic signed [17:0] COEF_Y        = 18'sd298;
  localparam logic signed [17:0] COEF_ROUND    = 18'sd128;
  localparam logic signed [17:0] COEF_BU       = 18'sd516;
  localparam logic signed [17:0] COEF_GU       = 18'sd100;
  localparam logic signed [17:0] COEF_GV       = 18'sd208;
  localparam logic signed [17:0] COEF_RV       = 18'sd409;

endpackage

`default_nettype wire

@@ rtl/core/camera_pixel_to_argb32_top.sv @@
// camera_pixel_to_argb32_top: camera source bytes to opaque ARGB32 pixels
// depends on cpa_pkg (types, format codes, conversion constants)
//
//  channel | ports                          | handshake
//  --------+--------------------------------+---------------------------
//  input   | in_valid, in_stall, in_data    | taken on valid && !stall
//  result  | out_valid, out_stall, out_data | taken on valid && !stall
//  config  | cfg_valid, cfg_ready, cfg_data | written on valid && ready
//
// three register stages (products, sums, clip/pack), the last one driving out_data.
// one word per cycle for rgb24/rgb565/rgb444 while out_stall is low; a yuyv word
// stays in the output stage while its pair of pixels goes out one at a time.
// rst_n (synchronous) clears valid bits, the pair phase and the format (rgb24).
// each stage moves when the stage after it is empty or moving, so bubbles close
// up and out_stall reaches in_stall only when every stage is full.
`default_nettype none

module camera_pixel_to_argb32_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire cpa_pkg::in_word_t  in_data,
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      cpa_pkg::out_word_t out_data,
  input  wire logic               cfg_valid,
  output      logic               cfg_ready,
  input  wire logic [1:0]         cfg_data
);
  import cpa_pkg::*;

  // clip a scaled sum to one 8-bit channel
  function automatic logic [7:0] clip_chan(input logic signed [19:0] sum);
    logic [7:0] res;
    if (sum[19]) begin
      res = 8'd0;
    end else if (|sum[18:16]) begin
      res = 8'hFF;
    end else begin
      res = sum[15:8];
    end
    return res;
  endfunction

  // format register
  src_fmt_t fmt_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_RGB24;
    end else if (cfg_valid && cfg_ready) begin
      fmt_r <= src_fmt_t'(cfg_data);
    end
  end

  // stage valids and enables
  logic v1_r, v2_r, v3_r, phase_r, two_r;
  logic en1, en2, en3, out_fire, pop;

  assign out_valid = v3_r;
  assign out_fire  = v3_r && !out_stall;
  assign pop       = out_fire && (!two_r || phase_r);
  assign en3       = !v3_r || pop;
  assign en2       = !v2_r || en3;
  assign en1       = !v1_r || en2;
  assign in_stall  = !en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (pop) begin
        phase_r <= 1'b0;
      end else if (out_fire) begin
        phase_r <= 1'b1;
      end
    end
  end

  // stage 1: packed rgb formats and yuv products
  logic [7:0]         y1_b, y2_b;
  logic signed [8:0]  y1m, y2m, dm, em;
  logic signed [17:0] y1x, y2x, dx, ex;
  logic [23:0]        rgb_nxt, rgb1_r, rgb2_r;
  logic               yuv1_r, yuv2_r, fe1_r, fe2_r;
  logic signed [17:0] c1_nxt, c2_nxt, bu_nxt, gu_nxt, gv_nxt, rv_nxt;
  logic signed [17:0] c1_r, c2_r, bu_r, gu_r, gv_r, rv_r;

  assign y1_b = in_data.byte_zero;
  assign y2_b = in_data.byte_two;
  assign y1m  = $signed({1'b0, y1_b} - LUMA_OFFSET);
  assign y2m  = $signed({1'b0, y2_b} - LUMA_OFFSET);
  assign dm   = $signed({1'b0, in_data.byte_one} - CHROMA_OFFSET);
  assign em   = $signed({1'b0, in_data.byte_three} - CHROMA_OFFSET);
  assign y1x  = 18'(y1m);
  assign y2x  = 18'(y2m);
  assign dx   = 18'(dm);
  assign ex   = 18'(em);

  always_comb begin
    c1_nxt = y1x * COEF_Y + COEF_ROUND;
    c2_nxt = y2x * COEF_Y + COEF_ROUND;
    bu_nxt = dx * COEF_BU;
    gu_nxt = dx * COEF_GU;
    gv_nxt = ex * COEF_GV;
    rv_nxt = ex * COEF_RV;
    case (fmt_r)
      FMT_RGB565: begin
        rgb_nxt = {in_data.byte_one & 8'hF8,
                   in_data.byte_one[2:0], in_data.byte_zero[7:5], 2'b00,
                   in_data.byte_zero[4:0], 3'b000};
      end
      FMT_RGB444: begin
        rgb_nxt = {in_data.byte_one[3:0], 4'h0,
                   in_data.byte_zero[7:4], 4'h0,
                   in_data.byte_zero[3:0], 4'h0};
      end
      default: begin
        rgb_nxt = {in_data.byte_zero, in_data.byte_one, in_data.byte_two};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      rgb1_r <= rgb_nxt;
      yuv1_r <= (fmt_r == FMT_YUYV);
      fe1_r  <= in_data.frame_end;
      c1_r   <= c1_nxt;
      c2_r   <= c2_nxt;
      bu_r   <= bu_nxt;
      gu_r   <= gu_nxt;
      gv_r   <= gv_nxt;
      rv_r   <= rv_nxt;
    end
  end

  // stage 2: channel sums for both lumas
  logic signed [19:0] b1_nxt, g1_nxt, r1_nxt, b2_nxt, g2_nxt, r2_nxt;
  logic signed [19:0] b1_r, g1_r, r1_r, b2_r, g2_r, r2_r;

  always_comb begin
    b1_nxt = 20'(c1_r) + 20'(bu_r);
    g1_nxt = 20'(c1_r) - 20'(gu_r) - 20'(gv_r);
    r1_nxt = 20'(c1_r) + 20'(rv_r);
    b2_nxt = 20'(c2_r) + 20'(bu_r);
    g2_nxt = 20'(c2_r) - 20'(gu_r) - 20'(gv_r);
    r2_nxt = 20'(c2_r) + 20'(rv_r);
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      rgb2_r <= rgb1_r;
      yuv2_r <= yuv1_r;
      fe2_r  <= fe1_r;
      b1_r   <= b1_nxt;
      g1_r   <= g1_nxt;
      r1_r   <= r1_nxt;
      b2_r   <= b2_nxt;
      g2_r   <= g2_nxt;
      r2_r   <= r2_nxt;
    end
  end

  // stage 3: clip and pack, held as the output pair
  logic [31:0] pix0_nxt, pix1_nxt, pix0_r, pix1_r;
  logic        fe3_r;

  always_comb begin
    if (yuv2_r) begin
      pix0_nxt = {ALPHA_OPAQUE, clip_chan(r1_r), clip_chan(g1_r), clip_chan(b1_r)};
    end else begin
      pix0_nxt = {ALPHA_OPAQUE, rgb2_r};
    end
    pix1_nxt = {ALPHA_OPAQUE, clip_chan(r2_r), clip_chan(g2_r), clip_chan(b2_r)};
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      pix0_r <= pix0_nxt;
      pix1_r <= pix1_nxt;
      two_r  <= yuv2_r;
      fe3_r  <= fe2_r;
    end
  end

  // output word: first pixel, then the second of a yuyv pair
  logic last_px;

  assign last_px                = !two_r || phase_r;
  assign out_data.pixel_argb    = phase_r ? pix1_r : pix0_r;
  assign out_data.last_of_item  = last_px;
  assign out_data.frame_end_out = last_px && fe3_r;

  // pair phase only while a yuyv pair sits in the output stage
  a_phase_pair: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> (v3_r && two_r))
    else $error("pair phase set without a yuyv pair in the output stage");

  // the first pixel of a pair is always followed by the last one
  a_pair_follow: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && !out_data.last_of_item) |=> (out_valid && out_data.last_of_item))
    else $error("second pixel of a yuyv pair missing");

  // input stalls only with every stage full
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v1_r && v2_r && v3_r))
    else $error("input stalled with an empty stage");

endmodule

`default_nettype wire

@@ sim/camera_pixel_to_argb32_tb.sv @@
// testbench for camera_pixel_to_argb32_top: sends source byte groups in all four
// formats and checks every pixel word against a built-in converter model
// depends on cpa_pkg and camera_pixel_to_argb32_top

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cpa_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [1:0] cfg_data;

  // format the converter model assumes, and pixels still owed by the block
  src_fmt_t  fmt_shadow;
  out_word_t pending_pixels[$];
  int        mismatch_count;
  bit        no_gaps;

  camera_pixel_to_argb32_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // bt.601 channel: floor shift by 8, then clip to 0..255
  function automatic logic [7:0] clip_channel(input int sum);
    int shifted;
    if (sum < 0) return 8'd0;
    shifted = sum >>> 8;
    if (shifted > 255) return 8'd255;
    return shifted[7:0];
  endfunction

  function automatic logic [31:0] yuv_to_argb(input logic [7:0] y, input logic [7:0] u,
                                              input logic [7:0] v);
    int c;
    int d;
    int e;
    c = (int'(y) - 16) * 298 + 128;
    d = int'(u) - 128;
    e = int'(v) - 128;
    return {8'hFF, clip_channel(c + 409 * e), clip_channel(c - 100 * d - 208 * e),
            clip_channel(c + 516 * d)};
  endfunction

  // queue the pixel words one accepted group should produce
  task automatic predict_pixels(input in_word_t grp);
    out_word_t px;
    px.last_of_item  = 1'b1;
    px.frame_end_out = grp.frame_end;
    case (fmt_shadow)
      FMT_YUYV: begin
        px.pixel_argb    = yuv_to_argb(grp.byte_zero, grp.byte_one, grp.byte_three);
        px.last_of_item  = 1'b0;
        px.frame_end_out = 1'b0;
        pending_pixels.push_back(px);
        px.pixel_argb    = yuv_to_argb(grp.byte_two, grp.byte_one, grp.byte_three);
        px.last_of_item  = 1'b1;
        px.frame_end_out = grp.frame_end;
      end
      FMT_RGB565: begin
        px.pixel_argb = {8'hFF, grp.byte_one[7:3], 3'b000,
                         grp.byte_one[2:0], grp.byte_zero[7:5], 2'b00,
                         grp.byte_zero[4:0], 3'b000};
      end
      FMT_RGB444: begin
        px.pixel_argb = {8'hFF, grp.byte_one[3:0], 4'h0, grp.byte_zero[7:4], 4'h0,
                         grp.byte_zero[3:0], 4'h0};
      end
      default: begin
        px.pixel_argb = {8'hFF, grp.byte_zero, grp.byte_one, grp.byte_two};
      end
    endcase
    pending_pixels.push_back(px);
  endtask

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 20) $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // idle lengths: mostly none or short, a few long, none during quiet stretches
  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // send one word and hold it until taken
  task automatic send_group(input in_word_t grp);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= grp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_pixels(grp);
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  function automatic in_word_t make_group(input logic [7:0] b0, input logic [7:0] b1,
                                          input logic [7:0] b2, input logic [7:0] b3,
                                          input logic fe);
    in_word_t grp;
    grp.byte_zero  = b0;
    grp.byte_one   = b1;
    grp.byte_two   = b2;
    grp.byte_three = b3;
    grp.frame_end  = fe;
    return grp;
  endfunction

  function automatic in_word_t random_group();
    return make_group(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                      $urandom_range(0, 7) == 0);
  endfunction

  // drop valid and wait until every owed pixel has come out
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // format register write, only with the pipeline empty
  task automatic write_format(input src_fmt_t fmt);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= fmt;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    fmt_shadow = fmt;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // format after reset is rgb24, no write needed
  task automatic test_reset_format();
    send_group(make_group(8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
    send_group(make_group(8'hFF, 8'hFF, 8'hFF, 8'hA5, 1'b1));
    send_group(make_group(8'h12, 8'h34, 8'h56, 8'hFF, 1'b0));
  endtask

  task automatic test_rgb24();
    write_format(FMT_RGB24);
    send_group(make_group(8'hAA, 8'h55, 8'h0F, 8'h00, 1'b1));
  endtask

  // yuyv extremes, neutral chroma, equal lumas, clipping both ways
  task automatic test_yuyv();
    write_format(FMT_YUYV);
    send_group(make_group(8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
    send_group(make_group(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1));
    send_group(make_group(8'd16, 8'd128, 8'd16, 8'd128, 1'b0));
    send_group(make_group(8'd235, 8'd0, 8'd16, 8'd255, 1'b1));
    send_group(make_group(8'd128, 8'd255, 8'd128, 8'd0, 1'b0));
  endtask

  // rgb565 single channels at full scale, unused bytes set
  task automatic test_rgb565();
    write_format(FMT_RGB565);
    send_group(make_group(8'h00, 8'h00, 8'hFF, 8'hFF, 1'b0));
    send_group(make_group(8'hFF, 8'hFF, 8'h00, 8'h00, 1'b1));
    send_group(make_group(8'hE0, 8'h07, 8'h5A, 8'hA5, 1'b0));
    send_group(make_group(8'h00, 8'hF8, 8'h00, 8'h00, 1'b0));
    send_group(make_group(8'h1F, 8'h00, 8'h00, 8'h00, 1'b1));
  endtask

  // rgb444 with the ignored top nibble of the high byte set and clear
  task automatic test_rgb444();
    write_format(FMT_RGB444);
    send_group(make_group(8'h00, 8'h00, 8'hFF, 8'hFF, 1'b0));
    send_group(make_group(8'hFF, 8'hFF, 8'h00, 8'h00, 1'b1));
    send_group(make_group(8'hF0, 8'hF0, 8'h00, 8'h00, 1'b0));
    send_group(make_group(8'h0F, 8'h0F, 8'h33, 8'hCC, 1'b1));
  endtask

  // random words in phases, each phase opening with a format write
  task automatic test_random_phases();
    src_fmt_t fmt;
    for (int phase = 0; phase < 8; phase++) begin
      fmt = (phase < 4) ? src_fmt_t'(3 - phase) : src_fmt_t'($urandom_range(0, 3));
      write_format(fmt);
      repeat (160) send_group(random_group());
    end
  endtask

  // result side: compare each taken pixel with the oldest one owed
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected pixel %h", out_data.pixel_argb));
      end else begin
        want = pending_pixels.pop_front();
        if (out_data.pixel_argb !== want.pixel_argb)
          report_mismatch($sformatf("pixel_argb %h, want %h", out_data.pixel_argb,
                                    want.pixel_argb));
        if (out_data.last_of_item !== want.last_of_item)
          report_mismatch($sformatf("last_of_item %b, want %b", out_data.last_of_item,
                                    want.last_of_item));
        if (out_data.frame_end_out !== want.frame_end_out)
          report_mismatch($sformatf("frame_end_out %b, want %b", out_data.frame_end_out,
                                    want.frame_end_out));
      end
    end
  end

  // receiver stalls of random length
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!no_gaps && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(4, 30)) @(negedge clk);
        else repeat ($urandom_range(1, 3)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // stretches with no idling on either side
  initial begin
    no_gaps = 1'b0;
    forever begin
      repeat ($urandom_range(100, 400)) @(posedge clk);
      no_gaps = ($urandom_range(0, 3) == 0);
    end
  end

  // hang guard
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // main sequence
  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    cfg_valid      = 1'b0;
    cfg_data       = FMT_RGB24;
    fmt_shadow     = FMT_RGB24;
    mismatch_count = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_format();
    test_rgb24();
    test_yuyv();
    test_rgb565();
    test_rgb444();
    test_random_phases();
    drain();
    repeat (10) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/cpa_pkg.sv
rtl/core/camera_pixel_to_argb32_top.sv
sim/camera_pixel_to_argb32_tb.sv
